// ===== sv/bls_pkg.sv =====
// Shared types and constants for the bounded LIFO stack.
package bls_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned LimitWidth = 5;
  localparam int unsigned CountWidth = 5;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PUSH   = 2'd1,
    CELL_POP    = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SHOW = 1'b1
  } fsm_state_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic signed [WordWidth-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    status_t                     status;
    logic signed [WordWidth-1:0] out_value;
    logic                        is_empty;
    logic                        is_full;
    logic [CountWidth-1:0]       entry_count;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    cell_op_t                    op;
    logic signed [WordWidth-1:0] data;
  } cell_ctrl_t;

endpackage

// ===== sv/bounded_lifo_stack.sv =====
// Top level of the bounded LIFO stack built as a shifting row of cells.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid / in_ready       in_item (cmd, push_value)
//   out       output     out_valid / out_ready     out_item (status .. last)
//   cfg       input      cfg_wr_en                 cfg_wr_data (stack_limit)
//
// Push, pop and peek give one output transfer each; cell 0 is the top while idle.
// A display sends one transfer per held entry, rotating the row through cell 0.
// Synchronous reset empties the stack and sets the limit to 16.
// A transfer is taken only when idle and the output register is free or drained.
module bounded_lifo_stack #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  bls_pkg::in_item_t                     in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bls_pkg::out_item_t                    out_item,
  input  logic                                  cfg_wr_en,
  input  logic [bls_pkg::LimitWidth-1:0]        cfg_wr_data
);
  import bls_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [WordWidth-1:0] cells [DEPTH];
  logic [DEPTH-1:0]            wrap;

  fsm_state_t                  state, state_next;
  logic [CW-1:0]               count, count_next;
  logic [CW-1:0]               remain, remain_next;
  logic [LimitWidth-1:0]       stack_limit;
  cell_ctrl_t                  ctrl;
  logic                        load;
  logic                        out_free;
  logic                        accept;
  logic                        full;
  logic [31:0]                 lim32;
  logic [31:0]                 cnt_next32;
  status_t                     res_status;
  logic signed [WordWidth-1:0] res_value;
  logic                        res_last;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WordWidth-1:0] up_v, down_v;
    if (i == 0) begin : g_first
      assign up_v = ctrl.data;
    end else begin : g_mid
      assign up_v = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_final
      assign down_v = cells[i];
    end else begin : g_inner
      assign down_v = cells[i+1];
    end
    assign wrap[i] = (count == CW'(i + 1));
    bls_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wrap       (wrap[i]),
      .up_value   (up_v),
      .down_value (down_v),
      .value      (cells[i])
    );
  end

  assign lim32 = (stack_limit == '0) ? 32'd1 :
                 (32'(stack_limit) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(stack_limit);
  assign full       = 32'(count) >= lim32;
  assign cnt_next32 = 32'(count_next);
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == FSM_IDLE) && out_free;
  assign accept     = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    count_next  = count;
    remain_next = remain;
    ctrl.op     = CELL_HOLD;
    ctrl.data   = cells[0];
    load        = 1'b0;
    res_status  = STAT_OK;
    res_value   = '0;
    res_last    = 1'b1;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (in_item.cmd)
            CMD_PUSH: begin
              if (full) begin
                res_status = STAT_OVERFLOW;
              end else begin
                ctrl.op    = CELL_PUSH;
                ctrl.data  = in_item.push_value;
                count_next = count + 1'b1;
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_value  = cells[0];
                ctrl.op    = CELL_POP;
                count_next = count - 1'b1;
              end
            end
            CMD_PEEK: begin
              if (count == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_value = cells[0];
              end
            end
            CMD_DISPLAY: begin
              if (count == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_value   = cells[0];
                ctrl.op     = CELL_ROTATE;
                res_last    = (count == CW'(1));
                remain_next = count - 1'b1;
                if (count != CW'(1)) begin
                  state_next = FSM_SHOW;
                end
              end
            end
            default: res_status = STAT_OK;
          endcase
        end
      end
      FSM_SHOW: begin
        if (out_free) begin
          load        = 1'b1;
          res_value   = cells[0];
          ctrl.op     = CELL_ROTATE;
          res_last    = (remain == CW'(1));
          remain_next = remain - 1'b1;
          if (remain == CW'(1)) begin
            state_next = FSM_IDLE;
          end
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FSM_IDLE;
      count       <= '0;
      remain      <= '0;
      stack_limit <= LimitWidth'(16);
      out_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (cfg_wr_en) begin
        stack_limit <= cfg_wr_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.status      <= res_status;
      out_item.out_value   <= res_value;
      out_item.is_empty    <= (count_next == '0);
      out_item.is_full     <= (cnt_next32 >= lim32);
      out_item.entry_count <= cnt_next32[CountWidth-1:0];
      out_item.last        <= res_last;
    end
  end

endmodule

// ===== sv/bls_cell.sv =====
// One stack cell: holds a word and moves it toward its neighbors on command.
module bls_cell (
  input  logic                                  clk,
  input  bls_pkg::cell_ctrl_t                   ctrl,
  input  logic                                  wrap,
  input  logic signed [bls_pkg::WordWidth-1:0]  up_value,
  input  logic signed [bls_pkg::WordWidth-1:0]  down_value,
  output logic signed [bls_pkg::WordWidth-1:0]  value
);
  import bls_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD:   value <= value;
      CELL_PUSH:   value <= up_value;
      CELL_POP:    value <= down_value;
      CELL_ROTATE: value <= wrap ? ctrl.data : down_value;
      default:     value <= value;
    endcase
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the bounded LIFO stack, predicting every output transfer.
module tb;
  import bls_pkg::*;

  localparam int Depth       = 16;
  localparam int HoldCycles  = 200;
  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 20;
  localparam int RandomBatch = 27;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_wr_en = 1'b0;
  logic [LimitWidth-1:0] cfg_wr_data = '0;

  logic signed [WordWidth-1:0] entries [Depth];
  int unsigned                 depth_used = 0;
  logic [LimitWidth-1:0]       limit_reg = 5'd16;
  out_item_t                   exp_q [$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int overflows = 0;
  int empties = 0;
  int displays = 0;
  int limit_writes = 0;

  bounded_lifo_stack #(
    .DEPTH(Depth)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned active_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > Depth) return Depth;
    return limit_reg;
  endfunction

  function automatic out_item_t stack_result(input status_t st,
                                             input logic signed [WordWidth-1:0] v,
                                             input logic fin);
    out_item_t r;
    r.status      = st;
    r.out_value   = v;
    r.is_empty    = (depth_used == 0);
    r.is_full     = (depth_used >= active_limit());
    r.entry_count = depth_used[CountWidth-1:0];
    r.last        = fin;
    return r;
  endfunction

  function automatic logic signed [WordWidth-1:0] pick_word();
    case ($urandom_range(15))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic predict_results(input in_item_t it);
    int i;
    logic signed [WordWidth-1:0] top;
    items_sent++;
    case (it.cmd)
      CMD_PUSH: begin
        if (depth_used >= active_limit() || depth_used >= Depth) begin
          overflows++;
          exp_q.push_back(stack_result(STAT_OVERFLOW, '0, 1'b1));
        end else begin
          entries[depth_used] = it.push_value;
          depth_used++;
          exp_q.push_back(stack_result(STAT_OK, '0, 1'b1));
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (depth_used == 0) begin
          empties++;
          exp_q.push_back(stack_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          top = entries[depth_used-1];
          if (it.cmd == CMD_POP) depth_used--;
          exp_q.push_back(stack_result(STAT_OK, top, 1'b1));
        end
      end
      default: begin
        displays++;
        if (depth_used == 0) begin
          empties++;
          exp_q.push_back(stack_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          for (i = depth_used - 1; i >= 0; i--) begin
            exp_q.push_back(stack_result(STAT_OK, entries[i], i == 0));
          end
        end
      end
    endcase
  endtask

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 40) $display("Mismatch %0d at %0t: %s", errors, $realtime, msg);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (exp_q.size() == 0) begin
      report_error($sformatf("transfer with nothing expected, status %0d value %0d",
                             got.status, got.out_value));
    end else begin
      want = exp_q.pop_front();
      if (got.status !== want.status)
        report_error($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.out_value !== want.out_value)
        report_error($sformatf("out_value %0d, expected %0d", got.out_value, want.out_value));
      if (got.is_empty !== want.is_empty)
        report_error($sformatf("is_empty %0b, expected %0b", got.is_empty, want.is_empty));
      if (got.is_full !== want.is_full)
        report_error($sformatf("is_full %0b, expected %0b", got.is_full, want.is_full));
      if (got.entry_count !== want.entry_count)
        report_error($sformatf("entry_count %0d, expected %0d",
                               got.entry_count, want.entry_count));
      if (got.last !== want.last)
        report_error($sformatf("last %0b, expected %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_item);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("Timeout: no transfer for %0d cycles", StallLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_cmd(input cmd_t c, input logic signed [WordWidth-1:0] v);
    in_item_t item;
    item.cmd        = c;
    item.push_value = v;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_results(item);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LimitWidth-1:0] v);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
    limit_writes++;
  endtask

  task automatic set_idle(input int s, input int r);
    send_idle = s;
    recv_idle <= r;
  endtask

  task automatic check_empty_stack();
    send_cmd(CMD_POP, 32'sh7FFFFFFF);
    send_cmd(CMD_PEEK, 32'sh80000000);
    send_cmd(CMD_DISPLAY, -1);
  endtask

  task automatic check_fill_and_overflow();
    int k;
    send_cmd(CMD_PUSH, 32'sh7FFFFFFF);
    send_cmd(CMD_PUSH, 32'sh80000000);
    send_cmd(CMD_PUSH, '0);
    send_cmd(CMD_PUSH, -1);
    send_cmd(CMD_PUSH, 32'sh55555555);
    send_cmd(CMD_PUSH, 32'shAAAAAAAA);
    for (k = 6; k < Depth; k++) send_cmd(CMD_PUSH, $urandom);
    send_cmd(CMD_PUSH, 32'sh12345678);
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_DISPLAY, '0);
  endtask

  // A zero limit behaves as one and a limit above the depth as the depth.
  task automatic check_limit_edges();
    write_limit(5'd0);
    send_cmd(CMD_PUSH, pick_word());
    send_cmd(CMD_POP, pick_word());
    write_limit(5'd31);
    send_cmd(CMD_PUSH, pick_word());
  endtask

  task automatic check_output_stall();
    int k;
    cmd_t c;
    hold_token <= hold_token + 1;
    for (k = 0; k < 12; k++) begin
      c = CMD_PUSH;
      if (k % 3 == 2) c = CMD_POP;
      send_cmd(c, $urandom);
    end
  endtask

  task automatic check_sender_pause();
    int k;
    for (k = 0; k < 8; k++) send_cmd(CMD_PUSH, pick_word());
    wait_drain();
    send_cmd(CMD_DISPLAY, pick_word());
    for (k = 0; k < 7; k++) send_cmd(CMD_POP, pick_word());
  endtask

  task automatic run_random_mix(input logic [LimitWidth-1:0] lim);
    int k;
    int push_pct;
    int r;
    cmd_t c;
    write_limit(lim);
    push_pct = 50;
    for (k = 0; k < RandomBatch; k++) begin
      if (k % 9 == 0) push_pct = $urandom_range(85, 25);
      r = $urandom_range(99);
      if (r < push_pct) begin
        c = CMD_PUSH;
      end else begin
        r = $urandom_range(9);
        if (r < 6) c = CMD_POP;
        else if (r < 8) c = CMD_PEEK;
        else c = CMD_DISPLAY;
      end
      send_cmd(c, pick_word());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_idle(7, 88);
    check_empty_stack();
    check_fill_and_overflow();
    check_limit_edges();
    check_output_stall();
    check_sender_pause();
    run_random_mix(5'd16);
    run_random_mix(5'd3);
    set_idle(88, 7);
    run_random_mix(5'd1);
    run_random_mix(5'd31);
    set_idle(0, 0);
    run_random_mix(5'($urandom_range(31)));
    run_random_mix(5'($urandom_range(15, 2)));
    wait_drain();
    repeat (DrainCycles) @(posedge clk);
    $display("Run covered %0d items and %0d output transfers across %0d limit writes.",
             items_sent, results_seen, limit_writes);
    $display("Overflow responses %0d, empty responses %0d, display commands %0d.",
             overflows, empties, displays);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bls_pkg.sv
sv/bls_cell.sv
sv/bounded_lifo_stack.sv
bench/tb.sv
